@@ rtl/sita_pkg.sv @@
// shared constants, types and digit mapping for the integer to text unit
package sita_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int MAX_DIGITS  = 32;
  localparam int DIGIT_BITS  = 6;
  localparam int RADIX_BITS  = 6;
  localparam int ADDR_BITS   = $clog2(MAX_DIGITS);
  localparam int COUNT_BITS  = $clog2(MAX_DIGITS + 1);
  localparam int CHAR_BITS   = 8;

  // quotient bits resolved per divider cycle
  localparam int STEPS       = 8;
  localparam int DIV_CYCLES  = (VALUE_BITS + STEPS - 1) / STEPS;
  localparam int DIV_WIDTH   = DIV_CYCLES * STEPS;
  localparam int CYC_BITS    = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);

  localparam logic [CHAR_BITS-1:0]  LETTER_OFFSET = CHAR_BITS'(87);
  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO     = 8'h30;
  localparam logic [CHAR_BITS-1:0]  CHAR_MINUS    = 8'h2d;
  localparam logic [DIGIT_BITS-1:0] DIGIT_LIMIT   = DIGIT_BITS'(10);

  typedef struct packed {
    logic                  negative;
    logic [VALUE_BITS-1:0] magnitude;
    logic [RADIX_BITS-1:0] radix;
  } job_t;

  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] wide;
    wide = CHAR_BITS'(d);
    if (d >= DIGIT_LIMIT) begin
      return wide + LETTER_OFFSET;
    end
    return wide + CHAR_ZERO;
  endfunction

endpackage

@@ rtl/sita_if.sv @@
// valid/ready channels for input numbers and output characters
interface sita_value_if;
  logic                                valid;
  logic                                ready;
  logic signed [sita_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sita_char_if;
  logic                               valid;
  logic                               ready;
  logic [sita_pkg::CHAR_BITS-1:0]     character;
  logic                               last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

@@ rtl/sita_front.sv @@
// front end: takes numbers, splits off the sign and forms the magnitude
module sita_front (
  sita_value_if.sink                    number,
  input  logic [sita_pkg::RADIX_BITS-1:0] radix,
  input  logic                          q_full,
  output logic                          q_push,
  output sita_pkg::job_t                q_job
);
  import sita_pkg::*;

  logic [VALUE_BITS-1:0] raw;

  assign raw          = VALUE_BITS'(number.value);
  assign number.ready = !q_full;
  assign q_push       = number.valid && !q_full;

  always_comb begin
    q_job.negative  = raw[VALUE_BITS-1];
    // two's complement negate, modulo 2^n so the most negative value survives
    q_job.magnitude = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
    q_job.radix     = radix;
  end
endmodule

@@ rtl/sita_queue.sv @@
// short job queue between front and back ends
module sita_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sita_pkg::job_t push_job,
  input  logic           pop,
  output sita_pkg::job_t head,
  output logic           full,
  output logic           empty
);
  import sita_pkg::*;

  job_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] fill;

  assign full  = (fill == QCNT_BITS'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + QCNT_BITS'(1);
        2'b01:   fill <= fill - QCNT_BITS'(1);
        default: fill <= fill;
      endcase
    end
  end
endmodule

@@ rtl/sita_back.sv @@
// back end: digit divider, digit store and character sequencer
module sita_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  sita_pkg::job_t q_head,
  output logic           q_pop,
  sita_char_if.source    chars
);
  import sita_pkg::*;

  typedef enum logic [2:0] {IDLE, DIVIDE, SIGN, READ, SHOW} state_t;

  state_t                 state;
  logic                   negative;
  logic [RADIX_BITS-1:0]  radix;
  logic [DIV_WIDTH-1:0]   quot;
  logic [RADIX_BITS-1:0]  rem;
  logic [CYC_BITS-1:0]    cyc;
  logic [COUNT_BITS-1:0]  count;
  logic [ADDR_BITS-1:0]   ptr;

  logic [DIGIT_BITS-1:0]  store [MAX_DIGITS];
  logic [DIGIT_BITS-1:0]  rd_data;

  logic [DIV_WIDTH-1:0]   quot_next;
  logic [RADIX_BITS-1:0]  rem_next;
  logic                   div_done;
  logic                   conv_done;

  // eight restoring steps on the narrow partial remainder
  always_comb begin
    logic [RADIX_BITS:0]  r;
    logic [DIV_WIDTH-1:0] q;
    r = '0;
    q = quot;
    rem_next = rem;
    for (int i = 0; i < STEPS; i++) begin
      r = {rem_next, q[DIV_WIDTH-1]};
      q = {q[DIV_WIDTH-2:0], 1'b0};
      if (r >= {1'b0, radix}) begin
        r    = r - {1'b0, radix};
        q[0] = 1'b1;
      end
      rem_next = r[RADIX_BITS-1:0];
    end
    quot_next = q;
  end

  assign div_done  = (cyc == CYC_BITS'(DIV_CYCLES - 1));
  assign conv_done = (quot_next == '0) || (count == COUNT_BITS'(MAX_DIGITS - 1));
  assign q_pop     = (state == IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if ((state == DIVIDE) && div_done) begin
      store[count[ADDR_BITS-1:0]] <= DIGIT_BITS'(rem_next);
    end
    rd_data <= store[ptr];
  end

  assign chars.valid     = (state == SIGN) || (state == SHOW);
  assign chars.character = (state == SIGN) ? CHAR_MINUS : digit_char(rd_data);
  assign chars.last      = (state == SHOW) && (ptr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      negative <= 1'b0;
      radix    <= RADIX_RESET;
      quot     <= '0;
      rem      <= '0;
      cyc      <= '0;
      count    <= '0;
      ptr      <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (!q_empty) begin
            negative <= q_head.negative;
            radix    <= q_head.radix;
            quot     <= DIV_WIDTH'(q_head.magnitude);
            rem      <= '0;
            cyc      <= '0;
            count    <= '0;
            state    <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (div_done) begin
            count <= count + COUNT_BITS'(1);
            // last digit written sits at the old count
            ptr   <= count[ADDR_BITS-1:0];
            quot  <= quot_next;
            rem   <= '0;
            cyc   <= '0;
            if (conv_done) begin
              state <= negative ? SIGN : READ;
            end
          end else begin
            quot <= quot_next;
            rem  <= rem_next;
            cyc  <= cyc + CYC_BITS'(1);
          end
        end
        SIGN: begin
          if (chars.ready) begin
            state <= READ;
          end
        end
        READ: begin
          state <= SHOW;
        end
        SHOW: begin
          if (chars.ready) begin
            if (ptr == '0) begin
              state <= IDLE;
            end else begin
              ptr   <= ptr - ADDR_BITS'(1);
              state <= READ;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

@@ rtl/signed_integer_to_ascii_unit.sv @@
// signed integer to ascii text, top level with radix register
// flow: an accepted number is registered into the job queue, the back end pops it when idle,
// the divider forms each digit (eight quotient bits a cycle), then the sign and digits are shown
// one number is converted at a time; the output stalls while chars.ready is low
// the divider and the digit store set the pace; the queue holds two numbers
// reset (synchronous, active high) sets radix to ten and empties queue and sequencer
module signed_integer_to_ascii_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sita_pkg::RADIX_BITS-1:0] cfg_data,
  sita_value_if.sink                    number,
  sita_char_if.source                   chars
);
  import sita_pkg::*;

  logic [RADIX_BITS-1:0] radix;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  job_t                  q_job;
  job_t                  q_head;

  // writes outside the legal range clamp to the nearest bound
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_write) begin
      if (cfg_data < RADIX_MIN) begin
        radix <= RADIX_MIN;
      end else if (cfg_data > RADIX_MAX) begin
        radix <= RADIX_MAX;
      end else begin
        radix <= cfg_data;
      end
    end
  end

  sita_front u_front (
    .number (number),
    .radix  (radix),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  sita_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  sita_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .chars   (chars)
  );

  a_radix_legal: assert property (@(posedge clk) disable iff (rst)
    radix >= RADIX_MIN && radix <= RADIX_MAX)
    else $error("radix register left its legal range");

  a_low_clamp: assert property (@(posedge clk) disable iff (rst)
    cfg_write && cfg_data < RADIX_MIN |=> radix == RADIX_MIN)
    else $error("low radix write not clamped");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    number.valid && number.ready |=> !q_empty)
    else $error("accepted word missing from job queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job taken from empty queue");

endmodule

@@ bench/testbench.sv @@
// self-checking bench for the signed integer to ascii unit
`timescale 1ns / 1ps

module testbench;
  import sita_pkg::*;

  typedef struct packed {
    logic [CHAR_BITS-1:0] character;
    logic                 last;
  } text_char_t;

  localparam logic [CHAR_BITS-1:0] ASCII_MINUS = "-";
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = "0";
  localparam logic [CHAR_BITS-1:0] ALPHA_SHIFT = 8'd87;
  localparam int                   DECIMAL     = 10;
  localparam logic [VALUE_BITS-1:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_BITS-1:0] INT_MIN = 32'h8000_0000;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [RADIX_BITS-1:0] cfg_data;

  sita_value_if number_ch ();
  sita_char_if  text_ch ();

  signed_integer_to_ascii_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .number   (number_ch),
    .chars    (text_ch)
  );

  logic [VALUE_BITS-1:0] pending_values[$];
  text_char_t            expected_chars[$];
  logic [RADIX_BITS-1:0] radix_copy;
  int                    error_count;
  int                    burst_left;
  int                    gap_left;
  int                    stall_left;
  int                    stall_max;
  int                    pattern_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] v);
    if (v < 2) begin
      return RADIX_BITS'(2);
    end
    if (v > 36) begin
      return RADIX_BITS'(36);
    end
    return v;
  endfunction

  // work out the characters one number turns into
  task automatic predict_text(input logic [VALUE_BITS-1:0] v, input logic [RADIX_BITS-1:0] base);
    logic [VALUE_BITS-1:0] mag;
    logic [5:0]            digits[$];
    logic [5:0]            d;
    text_char_t            c;
    mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    do begin
      digits.push_back(6'(mag % base));
      mag = mag / base;
    end while (mag != 0 && digits.size() < MAX_DIGITS);
    if (v[VALUE_BITS-1]) begin
      c.character = ASCII_MINUS;
      c.last      = 1'b0;
      expected_chars.push_back(c);
    end
    for (int k = digits.size() - 1; k >= 0; k--) begin
      d = digits[k];
      c.character = (d >= DECIMAL) ? CHAR_BITS'(d) + ALPHA_SHIFT : CHAR_BITS'(d) + ASCII_ZERO;
      c.last      = (k == 0);
      expected_chars.push_back(c);
    end
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value(input logic [RADIX_BITS-1:0] base);
    logic [63:0] p;
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5: v = VALUE_BITS'($urandom_range(0, 1000));
      6: v = ($urandom_range(0, 1) != 0) ? INT_MAX - $urandom_range(0, 3)
                                          : INT_MIN + $urandom_range(0, 3);
      7: begin
        // sits next to a power of the radix, where the digit count steps
        p = 1;
        repeat ($urandom_range(1, 32)) begin
          if (p * base <= 64'h8000_0000) begin
            p = p * base;
          end
        end
        v = VALUE_BITS'(p + $urandom_range(0, 2) - 1);
      end
      8: v = VALUE_BITS'($urandom_range(0, 2)) - 1'b1;
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 2) == 0) begin
      v = ~v + 1'b1;
    end
    return v;
  endfunction

  // sender: bursts of words with random gaps
  always @(posedge clk) begin
    if (rst) begin
      number_ch.valid <= 1'b0;
      number_ch.value <= '0;
      burst_left = $urandom_range(1, 20);
      gap_left   = 0;
    end else if (!(number_ch.valid && !number_ch.ready)) begin
      if (number_ch.valid && number_ch.ready) begin
        predict_text(number_ch.value, radix_copy);
        void'(pending_values.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
        number_ch.valid <= 1'b0;
      end else if (pending_values.size() > 0) begin
        number_ch.valid <= 1'b1;
        number_ch.value <= pending_values[0];
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        number_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: picks a new stall pattern whenever its pattern counter runs out, one setting never stalls
  always @(posedge clk) begin
    if (rst) begin
      text_ch.ready <= 1'b0;
      stall_left     = 0;
      stall_max      = 0;
      pattern_cycles = 0;
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected word: character %h last %b", text_ch.character, text_ch.last);
          error_count++;
        end else begin
          if (text_ch.character !== expected_chars[0].character) begin
            $error("character: expected %h, actual %h",
                   expected_chars[0].character, text_ch.character);
            error_count++;
          end
          if (text_ch.last !== expected_chars[0].last) begin
            $error("last: expected %b, actual %b", expected_chars[0].last, text_ch.last);
            error_count++;
          end
          void'(expected_chars.pop_front());
        end
      end
      if (pattern_cycles == 0) begin
        pattern_cycles = $urandom_range(200, 600);
        case ($urandom_range(0, 3))
          0: stall_max = 0;
          1: stall_max = 1;
          2: stall_max = 4;
          default: stall_max = 20;
        endcase
      end
      pattern_cycles--;
      if (stall_left > 0) begin
        stall_left--;
        text_ch.ready <= 1'b0;
      end else if (stall_max > 0 && $urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(0, stall_max - 1);
        text_ch.ready <= 1'b0;
      end else begin
        text_ch.ready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pending_values.size() != 0 || number_ch.valid || expected_chars.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_radix(input logic [RADIX_BITS-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    radix_copy = clamp_radix(v);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [RADIX_BITS-1:0] settings[$];
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_data        = '0;
    number_ch.valid = 1'b0;
    number_ch.value = '0;
    text_ch.ready   = 1'b0;
    radix_copy      = RADIX_BITS'(DECIMAL);
    error_count     = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // radix ten after reset: zero, signs, extremes, digit count boundaries
    pending_values = '{32'd0, 32'd1, 32'hffff_ffff, INT_MAX, INT_MIN, 32'd9, 32'd10,
                       32'hffff_fff6, 32'd999_999_999, 32'd1_000_000_000, 32'd123_456_789,
                       32'hffff_ff9c};
    wait_drained();

    // largest radix: letter digits up to 'z'
    write_radix(RADIX_BITS'(36));
    pending_values = '{32'd35, 32'd36, 32'hffff_ffdc, 32'd1295, INT_MAX, INT_MIN};
    wait_drained();

    // smallest radix: longest strings
    write_radix(RADIX_BITS'(2));
    pending_values = '{INT_MIN, INT_MAX, 32'hffff_ffff, 32'd0};
    wait_drained();

    // radix writes in and out of range (out of range saturates to the nearest bound), random numbers for each
    settings = '{RADIX_BITS'(0), RADIX_BITS'(63), RADIX_BITS'(16), RADIX_BITS'(37),
                 RADIX_BITS'(1), RADIX_BITS'(8), RADIX_BITS'($urandom_range(0, 63)),
                 RADIX_BITS'($urandom_range(2, 36)), RADIX_BITS'($urandom_range(2, 36))};
    foreach (settings[i]) begin
      write_radix(settings[i]);
      repeat (42) pending_values.push_back(pick_value(radix_copy));
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
